FILE: hw/rtl/taylor_sine_cosine_tangent_core_defines.svh
// Assertion macros shared by the sine/cosine/tangent checker.
`ifndef TAYLOR_SINE_COSINE_TANGENT_CORE_DEFINES_SVH
`define TAYLOR_SINE_COSINE_TANGENT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TSCT_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TSCT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/tsct_pkg.sv
// Constants, widths and types for the sine/cosine/tangent core.
package tsct_pkg;

   localparam int FRAC_BITS = 16;

   // pi scaled by 2^60
   localparam logic [63:0] PI_2_60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q64 =
      (PI_2_60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
   localparam logic [63:0] HALF_PI_Q64 =
      (PI_2_60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
   localparam logic [63:0] TWO_PI_Q64 = 64'd2 * PI_Q64;

   // angle constants
   localparam int TW = FRAC_BITS + 3;
   localparam logic [TW-1:0] PI_Q      = TW'(PI_Q64);
   localparam logic [TW-1:0] HALF_PI_Q = TW'(HALF_PI_Q64);
   localparam logic [TW-1:0] TWO_PI_Q  = TW'(TWO_PI_Q64);

   // range reduction by reciprocal multiply
   localparam int XW  = 34;
   localparam int RS  = XW + 2;
   localparam int RW  = RS - FRAC_BITS;
   localparam logic [63:0] RECIP64 = ((64'd1 << RS) + TWO_PI_Q64 / 2) / TWO_PI_Q64;
   localparam logic [RW-1:0] RECIP = RW'(RECIP64);
   localparam int PRW = XW + RW + 1;
   localparam int QW  = PRW - RS;
   localparam int QTW = QW + TW + 1;

   // series widths
   localparam int MW  = FRAC_BITS + 1;
   localparam int U2W = FRAC_BITS + 2;
   localparam int U4W = FRAC_BITS + 3;
   localparam int U6W = FRAC_BITS + 4;
   localparam logic [63:0] ROUND64 = 64'd1 << (FRAC_BITS - 1);

   // exact constant division by 24 and 720
   localparam int DK     = FRAC_BITS + 16;
   localparam int R24W   = DK - 4;
   localparam int R720W  = DK - 9;
   localparam logic [R24W-1:0]  R24  = R24W'(((64'd1 << DK) + 64'd23) / 64'd24);
   localparam logic [R720W-1:0] R720 = R720W'(((64'd1 << DK) + 64'd719) / 64'd720);
   localparam int Y24W  = U4W + 1;
   localparam int Y720W = U6W + 1;
   localparam int P24W  = Y24W + R24W;
   localparam int P720W = Y720W + R720W;

   // series result, divider
   localparam int SW = FRAC_BITS + 3;
   localparam int DW = FRAC_BITS + 1;
   localparam int NW = 2 * FRAC_BITS + 2;
   localparam int LANE_DEPTH = 9;

   localparam logic [63:0] VAL_MAX64 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] VAL_NEG64 = 64'h0000_0000_8000_0000;

   typedef enum logic [1:0] {
      CMD_SINE    = 2'd0,
      CMD_COSINE  = 2'd1,
      CMD_TANGENT = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic signed [SW-1:0]   sin;
      logic signed [SW-1:0]   cos;
   } tag_type;

endpackage

FILE: hw/rtl/taylor_sine_cosine_tangent_core.sv
// Top level of the pipelined fixed-point sine, cosine and tangent core.
// One beat is accepted every cycle the output register is empty or being
// taken. The pipeline holds nine stages in each sine lane (reduction
// multiply, period multiply, correction, fold, three series products, two
// constant divides, sum), one stage forming the tangent dividend, one
// restoring-divide stage per quotient bit (NW = 2*FRAC_BITS+2) and the
// output register. Sine and cosine lanes always run in parallel; the
// command only picks the result. All stages advance together, so a stalled
// output holds the pipe intact.
module taylor_sine_cosine_tangent_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] angle
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [31:0] value
   output logic [0:0]   rsp_tuser    // [0] saturated
);
   import tsct_pkg::*;

   logic                    advance;
   logic signed [XW-1:0]    x_sin, x_cos;
   logic signed [SW-1:0]    lane_sin, lane_cos;

   logic                    lane_valid_ff [LANE_DEPTH];
   cmd_type                 lane_cmd_ff   [LANE_DEPTH];

   // divider pipeline, index 0 is the dividend/divisor setup stage
   logic                    div_valid_ff [NW+1];
   tag_type                 div_tag_ff   [NW+1];
   logic [DW-1:0]           div_rem_ff   [NW+1];
   logic [NW-1:0]           div_num_ff   [NW+1];
   logic [NW-1:0]           div_quo_ff   [NW+1];
   logic [DW-1:0]           div_den_ff   [NW+1];

   logic [DW-1:0]           abs_s, abs_c;
   logic [NW-1:0]           num_in;
   tag_type                 tag_in;

   logic                    out_valid_ff;
   logic [31:0]             out_value_ff, value_in;
   logic                    out_sat_ff, sat_in;

   // whole pipe moves when the output slot is free or drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign x_sin = $signed(XW'($signed(req_tdata)));
   assign x_cos = x_sin + $signed(XW'({1'b0, HALF_PI_Q}));

   tsct_sine_lane u_sin_lane (
      .clock      (clock),
      .advance    (advance),
      .angle_x    (x_sin),
      .sine_value (lane_sin)
   );

   tsct_sine_lane u_cos_lane (
      .clock      (clock),
      .advance    (advance),
      .angle_x    (x_cos),
      .sine_value (lane_cos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANE_DEPTH; k++) begin
            lane_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         lane_valid_ff[0] <= req_tvalid;
         for (int k = 1; k < LANE_DEPTH; k++) begin
            lane_valid_ff[k] <= lane_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_cmd_ff[0] <= cmd_type'(req_tuser);
         for (int k = 1; k < LANE_DEPTH; k++) begin
            lane_cmd_ff[k] <= lane_cmd_ff[k-1];
         end
      end
   end

   // tangent dividend: |s| * 2^F + |c|/2, rounds half away from zero
   always_comb begin
      abs_s  = (lane_sin < 0) ? DW'(-lane_sin) : DW'(lane_sin);
      abs_c  = (lane_cos < 0) ? DW'(-lane_cos) : DW'(lane_cos);
      num_in = (NW'(abs_s) << FRAC_BITS) + NW'(abs_c >> 1);
      tag_in.cmd = lane_cmd_ff[LANE_DEPTH-1];
      tag_in.sin = lane_sin;
      tag_in.cos = lane_cos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= lane_valid_ff[LANE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_tag_ff[0] <= tag_in;
         div_rem_ff[0] <= '0;
         div_num_ff[0] <= num_in;
         div_quo_ff[0] <= '0;
         div_den_ff[0] <= abs_c;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 1; j <= NW; j++) begin : g_div
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial  = {div_rem_ff[j-1], div_num_ff[j-1][NW-1]};
         take   = trial >= {1'b0, div_den_ff[j-1]};
         rem_in = take ? DW'(trial - {1'b0, div_den_ff[j-1]}) : DW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[j] <= div_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_tag_ff[j] <= div_tag_ff[j-1];
            div_rem_ff[j] <= rem_in;
            div_num_ff[j] <= {div_num_ff[j-1][NW-2:0], 1'b0};
            div_quo_ff[j] <= {div_quo_ff[j-1][NW-2:0], take};
            div_den_ff[j] <= div_den_ff[j-1];
         end
      end
   end

   // result select and tangent saturation
   always_comb begin
      logic [63:0] q64;
      logic        negq;
      q64      = 64'(div_quo_ff[NW]);
      negq     = (div_tag_ff[NW].sin < 0) != (div_tag_ff[NW].cos < 0);
      value_in = '0;
      sat_in   = 1'b0;
      case (div_tag_ff[NW].cmd)
         CMD_SINE: begin
            value_in = 32'(div_tag_ff[NW].sin);
         end
         CMD_COSINE: begin
            value_in = 32'(div_tag_ff[NW].cos);
         end
         CMD_TANGENT: begin
            if (div_tag_ff[NW].cos == 0) begin
               // zero cosine: pick the rail by the sine sign
               sat_in   = 1'b1;
               value_in = (div_tag_ff[NW].sin < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (!negq) begin
               if (q64 > VAL_MAX64) begin
                  sat_in   = 1'b1;
                  value_in = 32'h7FFF_FFFF;
               end else begin
                  value_in = 32'(q64);
               end
            end else begin
               if (q64 > VAL_NEG64) begin
                  sat_in   = 1'b1;
                  value_in = 32'h8000_0000;
               end else begin
                  value_in = 32'(64'd0 - q64);
               end
            end
         end
         default: begin
            value_in = '0;
            sat_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= value_in;
         out_sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_value_ff;
   assign rsp_tuser[0] = out_sat_ff;

endmodule

FILE: hw/rtl/tsct_sine_lane.sv
// Nine-stage sine lane: range reduction, fold and Taylor series.
module tsct_sine_lane (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [tsct_pkg::XW-1:0]      angle_x,
   output logic signed [tsct_pkg::SW-1:0]      sine_value
);
   import tsct_pkg::*;

   logic signed [XW-1:0]    x1_ff, x2_ff;
   logic signed [PRW-1:0]   prod1_ff, prod_in;
   logic signed [QTW-1:0]   qt2_ff, qt_in;
   logic signed [QW-1:0]    q1;
   logic signed [QTW-1:0]   diff;
   logic signed [TW+1:0]    r_raw, r_adj;
   logic [TW-1:0]           r3_ff;
   logic [TW-1:0]           fold_r;
   logic                    fold_neg;
   logic signed [TW:0]      u_val;
   logic [MW-1:0]           m4_ff, m_in;
   logic                    neg4_ff, neg5_ff, neg6_ff, neg7_ff, neg8_ff;
   logic [U2W-1:0]          u2_5_ff, u2_6_ff, u2_in;
   logic [U4W-1:0]          u4_6_ff, u4_in;
   logic [U2W-1:0]          a2_6_ff, a2_7_ff, a2_8_ff, a2_in;
   logic [U6W-1:0]          u6_7_ff, u6_in;
   logic [P24W-1:0]         p24_7_ff, p24_in;
   logic [P720W-1:0]        p720_8_ff, p720_in;
   logic [U4W-1:0]          a24_8_ff, a24_in;
   logic signed [SW:0]      poly;
   logic signed [SW-1:0]    s9_ff, s_in;

   always_comb begin
      prod_in = $signed(PRW'(angle_x)) * $signed(PRW'({1'b0, RECIP}));
      q1      = $signed(prod1_ff[PRW-1:RS]);
      qt_in   = $signed(QTW'(q1)) * $signed(QTW'({1'b0, TWO_PI_Q}));
      diff    = $signed(QTW'(x2_ff)) - qt2_ff;
      r_raw   = $signed(diff[TW+1:0]);
      // estimate is off by at most one period either way
      if (r_raw < 0) begin
         r_adj = r_raw + $signed({2'b00, TWO_PI_Q});
      end else if (r_raw >= $signed({2'b00, TWO_PI_Q})) begin
         r_adj = r_raw - $signed({2'b00, TWO_PI_Q});
      end else begin
         r_adj = r_raw;
      end
      // fold upper half circle
      if (r3_ff >= PI_Q) begin
         fold_r   = r3_ff - PI_Q;
         fold_neg = 1'b1;
      end else begin
         fold_r   = r3_ff;
         fold_neg = 1'b0;
      end
      u_val = $signed({1'b0, fold_r}) - $signed({1'b0, HALF_PI_Q});
      m_in  = (u_val < 0) ? MW'(-u_val) : MW'(u_val);
      u2_in = U2W'(((2*MW)'(m4_ff) * (2*MW)'(m4_ff) + (2*MW)'(ROUND64)) >> FRAC_BITS);
      u4_in = U4W'(((2*U2W)'(u2_5_ff) * (2*U2W)'(u2_5_ff) + (2*U2W)'(ROUND64))
                   >> FRAC_BITS);
      a2_in = U2W'(((U2W+1)'(u2_5_ff) + (U2W+1)'(1)) >> 1);
      u6_in = U6W'((((U4W+U2W)'(u4_6_ff) * (U4W+U2W)'(u2_6_ff))
                    + (U4W+U2W)'(ROUND64)) >> FRAC_BITS);
      p24_in  = (P24W'(u4_6_ff) + P24W'(12)) * P24W'(R24);
      p720_in = (P720W'(u6_7_ff) + P720W'(360)) * P720W'(R720);
      a24_in  = U4W'(p24_7_ff >> DK);
      poly = $signed((SW+1)'(64'd1 << FRAC_BITS))
           - $signed((SW+1)'(a2_8_ff))
           + $signed((SW+1)'(a24_8_ff))
           - $signed((SW+1)'(p720_8_ff >> DK));
      s_in = neg8_ff ? SW'(-poly) : SW'(poly);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff     <= angle_x;
         prod1_ff  <= prod_in;
         x2_ff     <= x1_ff;
         qt2_ff    <= qt_in;
         r3_ff     <= r_adj[TW-1:0];
         m4_ff     <= m_in;
         neg4_ff   <= fold_neg;
         u2_5_ff   <= u2_in;
         neg5_ff   <= neg4_ff;
         u2_6_ff   <= u2_5_ff;
         u4_6_ff   <= u4_in;
         a2_6_ff   <= a2_in;
         neg6_ff   <= neg5_ff;
         u6_7_ff   <= u6_in;
         p24_7_ff  <= p24_in;
         a2_7_ff   <= a2_6_ff;
         neg7_ff   <= neg6_ff;
         p720_8_ff <= p720_in;
         a24_8_ff  <= a24_in;
         a2_8_ff   <= a2_7_ff;
         neg8_ff   <= neg7_ff;
         s9_ff     <= s_in;
      end
   end

   assign sine_value = s9_ff;

endmodule

FILE: hw/rtl/tsct_checker.sv
// Port-level checker for the sine/cosine/tangent core, with its bind.
`include "taylor_sine_cosine_tangent_core_defines.svh"

module tsct_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [31:0]  req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // held result beat stays put
   `TSCT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   // a stalled output freezes the whole pipe, so no new beat is taken
   `TSCT_ASSERT_NOW(a_stall_blocks_input, rsp_tvalid && !rsp_tready, !req_tready, "input taken while output stalled")

   // saturation only ever shows one of the two rails
   `TSCT_ASSERT_NOW(a_sat_rail, rsp_tvalid && rsp_tuser[0], rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000, "saturated value off the rails")

   // pipe comes out of reset empty
   `TSCT_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind taylor_sine_cosine_tangent_core tsct_checker u_checker (.*);

FILE: test/taylor_sine_cosine_tangent_core_test.sv
// Testbench for the pipelined sine, cosine and tangent core.
`timescale 1ns / 100ps

module taylor_sine_cosine_tangent_core_test;
   import tsct_pkg::*;

   localparam int LATENCY = LANE_DEPTH + NW + 2;
   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam longint PI_L = longint'(PI_Q64);
   localparam longint HPI_L = longint'(HALF_PI_Q64);
   localparam longint TPI_L = longint'(TWO_PI_Q64);
   localparam longint MAX_L = 64'sd2147483647;
   localparam longint MIN_L = -64'sd2147483648;
   // command code with no operation behind it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] angle
   logic [1:0] req_tuser = '0;      // [1:0] cmd
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;          // [31:0] value
   logic [0:0] rsp_tuser;           // [0] saturated

   typedef struct packed {
      logic [31:0] value;
      logic        saturated;
   } trig_result_type;

   // Fixed-point series sine of an arbitrary (wide) angle.
   function automatic longint series_sine(longint a);
      longint r, u, p;
      longint unsigned m, u2, u4, u6, rnd;
      bit neg;
      rnd = longint'(1) << (FRAC_BITS - 1);
      r = a % TPI_L;
      if (r < 0) r += TPI_L;
      neg = 0;
      if (r >= PI_L) begin
         r -= PI_L;
         neg = 1;
      end
      u = r - HPI_L;
      m = (u < 0) ? -u : u;
      u2 = (m * m + rnd) >> FRAC_BITS;
      u4 = (u2 * u2 + rnd) >> FRAC_BITS;
      u6 = (u4 * u2 + rnd) >> FRAC_BITS;
      p = ONE_Q - longint'((u2 + 1) / 2) + longint'((u4 + 12) / 24)
          - longint'((u6 + 360) / 720);
      return neg ? -p : p;
   endfunction

   function automatic trig_result_type eval_trig(logic [1:0] cmd, logic [31:0] angle);
      trig_result_type res;
      longint a, s, c, v;
      longint unsigned ns, dc, q;
      a = longint'(signed'(angle));
      v = 0;
      res.saturated = 0;
      case (cmd)
         CMD_SINE: v = series_sine(a);
         CMD_COSINE: v = series_sine(a + HPI_L);
         CMD_TANGENT: begin
            s = series_sine(a);
            c = series_sine(a + HPI_L);
            if (c == 0) begin
               res.saturated = 1;
               v = (s < 0) ? MIN_L : MAX_L;
            end else begin
               ns = longint'((s < 0) ? -s : s) << FRAC_BITS;
               dc = (c < 0) ? -c : c;
               q = (ns + dc / 2) / dc;
               if ((s < 0) == (c < 0)) begin
                  if (q > MAX_L) begin
                     res.saturated = 1;
                     v = MAX_L;
                  end else v = q;
               end else begin
                  if (q > 64'd2147483648) begin
                     res.saturated = 1;
                     v = MIN_L;
                  end else v = -longint'(q);
               end
            end
         end
         default: v = 0;
      endcase
      res.value = v[31:0];
      return res;
   endfunction

   class trig_scoreboard_type;
      trig_result_type pending[$];
      int mismatches = 0;
      int checked = 0;
      int saturations = 0;

      function void note_request(logic [1:0] cmd, logic [31:0] angle);
         pending.push_back(eval_trig(cmd, angle));
      endfunction

      function void check_response(logic [31:0] value, logic saturated);
         trig_result_type exp_r;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: value %h sat %b", value, saturated);
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r.saturated) saturations++;
         if (exp_r.value !== value || exp_r.saturated !== saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected value %h sat %b, got value %h sat %b",
                        exp_r.value, exp_r.saturated, value, saturated);
         end
      endfunction
   endclass

   trig_scoreboard_type board = new();
   int sent = 0;
   bit hold_off = 0;

   taylor_sine_cosine_tangent_core uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Offer one beat, holding it until accepted at a rising edge.
   task automatic send_beat(logic [1:0] cmd, logic [31:0] angle, bit gappy);
      int g;
      g = gappy ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= angle;
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, angle);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_angle();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 2 * 32'(TPI_L)) - 32'(TPI_L)));
         2: return 32'(($urandom_range(0, 40) - 20) * HPI_L + $urandom_range(0, 6) - 3);
         3: return 32'(signed'($urandom_range(0, 4000)) - 2000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   // Receiver: random stalls, with one long hold-off while the sender is busy.
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 99) < 70) || (sent % 300 < 40);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser[0]);
   end

   initial begin
      @(negedge clock);
      while (sent < 900) @(negedge clock);
      hold_off = 1;
      repeat (200) @(negedge clock);
      hold_off = 0;
   end

   initial begin
      logic [31:0] corners[] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                 32'(HPI_L), 32'(-HPI_L), 32'(PI_L), 32'(TPI_L),
                                 32'(3 * HPI_L), 32'(TPI_L - 1), 32'h1};
      int idle;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      foreach (corners[i]) begin
         send_beat(CMD_SINE, corners[i], 0);
         send_beat(CMD_COSINE, corners[i], 0);
      end
      send_beat(CMD_TANGENT, 32'(HPI_L), 0);
      send_beat(CMD_TANGENT, 32'(-HPI_L), 0);
      send_beat(CMD_UNUSED, 32'h12345678, 0);
      repeat (1800)
         send_beat(2'($urandom_range(0, 3) == 3 ? CMD_TANGENT : $urandom_range(0, 2)),
                   random_angle(), ($urandom_range(0, 9) < 7));
      req_tvalid <= 0;
      idle = 0;
      while (board.pending.size() != 0 && idle < 100000) begin
         @(negedge clock);
         idle++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      $display("Sent %0d beats, checked %0d results, %0d saturated tangents.",
               sent, board.checked, board.saturations);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tsct_pkg.sv
hw/rtl/tsct_sine_lane.sv
hw/rtl/taylor_sine_cosine_tangent_core.sv
hw/rtl/tsct_checker.sv
test/taylor_sine_cosine_tangent_core_test.sv
